@@ rtl/core/pdsteer_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PD steering package
// Widths, constants, state codes and the smoothing weight table that the
// PD steering core uses.
// ----------------------------------------------------------------------------
package pdsteer_pkg;

    // Number of smoothing taps kept in the PD history.
    localparam int HISTORY_TAPS_DEF = 4;

    // Field widths.
    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int PD_W    = 32;
    localparam int ANGLE_W = 10;
    localparam int DUTY_W  = 12;
    localparam int CFG_IDX_W = 1;

    // Shared multiplier operand, product and accumulator widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 44;

    // Position of the integer part after smoothing (Q.16 times Q0.8).
    localparam int FRAC_SHIFT = 24;
    localparam int QUOT_W     = ACC_W - FRAC_SHIFT;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 1'b1;

    // Gain reset values and the gains forced by a ring element (Q8.8).
    localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 16'd1280;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 16'd512;
    localparam logic [GAIN_W-1:0] RING_KP          = 16'd1280;
    localparam logic [GAIN_W-1:0] RING_KD          = 16'd512;

    // Angle and duty limits.
    localparam logic signed [QUOT_W:0] ANGLE_MAX = 21'sd400;
    localparam logic signed [QUOT_W:0] ANGLE_MIN = -21'sd360;
    localparam logic signed [DUTY_W:0] DUTY_CENTRE = 13'sd3390;
    localparam logic signed [DUTY_W:0] DUTY_MAX    = 13'sd3750;
    localparam logic signed [DUTY_W:0] DUTY_MIN    = 13'sd2990;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PD,
        S_LOAD,
        S_FIR,
        S_OUT
    } t_state;

    // Smoothing weights in Q0.8, newest sample first.
    function automatic logic signed [MUL_B_W-1:0] tap_weight(input logic [1:0] idx);
        logic signed [MUL_B_W-1:0] w;
        case (idx)
            2'd0:    w = 18'sd205;
            2'd1:    w = 18'sd26;
            2'd2:    w = 18'sd15;
            2'd3:    w = 18'sd10;
            default: w = 18'sd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/pd_steering_with_smoothing_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PD steering core with output smoothing
// Forms a PD term from the track error, smooths the last PD terms with a
// short FIR, and returns a clamped steering angle and servo duty.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                     Payload
//  --------  ---------  ----------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall       i_track_error, i_ring_mode
//  out       source     o_out_valid / i_out_stall     o_steer_angle, o_pwm_duty
//  cfg       sink       i_cfg_we                      i_cfg_index, i_cfg_data
//
//  One beat passes the PD steps, the history load and the smoothing steps
//  before the result register is loaded; the single shared multiplier
//  forms both PD products and every smoothing product in turn.
//  A new beat is accepted in the cycle after the result has been loaded,
//  while that result may still wait in the output register.
//  Reset (synchronous, active low) clears the history, the last error and
//  the output valid, and restores the gains in use to their reset values.
//  A stall on the output holds the finished result and the sequencer in its
//  final step until the output register is free.
//
module pd_steering_with_smoothing_core #(
    parameter int HISTORY_TAPS = pdsteer_pkg::HISTORY_TAPS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Input channel.
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  signed [pdsteer_pkg::ERR_W-1:0] i_track_error,
    input  wire                                i_ring_mode,
    // Output channel.
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic signed [pdsteer_pkg::ANGLE_W-1:0] o_steer_angle,
    output logic [pdsteer_pkg::DUTY_W-1:0]     o_pwm_duty,
    // Configuration port.
    input  wire                                i_cfg_we,
    input  wire  [pdsteer_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [pdsteer_pkg::GAIN_W-1:0]     i_cfg_data
);

    localparam int TAP_W = (HISTORY_TAPS > 1) ? $clog2(HISTORY_TAPS) : 1;
    localparam int CNT_W = $clog2(HISTORY_TAPS + 1);
    localparam logic [CNT_W-1:0] FIR_LAST = CNT_W'(HISTORY_TAPS);
    localparam logic [CNT_W-1:0] PD_LAST  = CNT_W'(2);

    // Sequencer.
    pdsteer_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Captured item and controller state.
    logic signed [pdsteer_pkg::ERR_W-1:0] r_err;
    logic signed [pdsteer_pkg::ERR_W-1:0] r_last_err;
    logic [pdsteer_pkg::GAIN_W-1:0]       r_kp;
    logic [pdsteer_pkg::GAIN_W-1:0]       r_kd;
    logic signed [pdsteer_pkg::PD_W-1:0]  r_hist [HISTORY_TAPS];

    // Shared multiplier and accumulator.
    logic signed [pdsteer_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [pdsteer_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [pdsteer_pkg::MUL_P_W-1:0] w_mul_p;
    logic signed [pdsteer_pkg::ACC_W-1:0]   r_prod;
    logic signed [pdsteer_pkg::ACC_W-1:0]   r_acc;

    logic signed [pdsteer_pkg::ERR_W:0]   w_diff;
    logic signed [pdsteer_pkg::PD_W-1:0]  w_pd_sat;
    logic                                 w_in_acc;
    logic                                 w_out_free;

    // Result formation.
    logic signed [pdsteer_pkg::ACC_W-1:0]  w_mag;
    logic [pdsteer_pkg::QUOT_W-1:0]        w_quot;
    logic signed [pdsteer_pkg::QUOT_W:0]   w_angle_full;
    logic signed [pdsteer_pkg::QUOT_W:0]   w_angle_clamp;
    logic signed [pdsteer_pkg::ANGLE_W-1:0] w_angle;
    logic signed [pdsteer_pkg::DUTY_W:0]   w_duty_full;
    logic signed [pdsteer_pkg::DUTY_W:0]   w_duty_clamp;

    // The input side is open only while the sequencer is idle.
    assign o_in_stall = (r_state != pdsteer_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;

    // Derivative term input, one bit wider than the error.
    assign w_diff = {r_err[pdsteer_pkg::ERR_W-1], r_err}
                  - {r_last_err[pdsteer_pkg::ERR_W-1], r_last_err};

    // Operand selection for the shared multiplier. Gains are unsigned and
    // get a zero sign bit; errors and history samples are sign-extended.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            pdsteer_pkg::S_PD: begin
                if (r_cnt == '0) begin
                    w_mul_a = pdsteer_pkg::MUL_A_W'(r_err);
                    w_mul_b = $signed({2'b00, r_kp});
                end else begin
                    w_mul_a = pdsteer_pkg::MUL_A_W'(w_diff);
                    w_mul_b = $signed({2'b00, r_kd});
                end
            end
            pdsteer_pkg::S_FIR: begin
                w_mul_a = pdsteer_pkg::MUL_A_W'(r_hist[r_cnt[TAP_W-1:0]]);
                w_mul_b = pdsteer_pkg::tap_weight(2'(r_cnt[TAP_W-1:0]));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // The PD sum saturates to 32 bits when its upper bits are not a plain
    // sign extension.
    always_comb begin
        if (r_acc[pdsteer_pkg::ACC_W-1:pdsteer_pkg::PD_W-1] == '0 ||
            r_acc[pdsteer_pkg::ACC_W-1:pdsteer_pkg::PD_W-1] == '1) begin
            w_pd_sat = r_acc[pdsteer_pkg::PD_W-1:0];
        end else if (r_acc[pdsteer_pkg::ACC_W-1]) begin
            w_pd_sat = {1'b1, {(pdsteer_pkg::PD_W-1){1'b0}}};
        end else begin
            w_pd_sat = {1'b0, {(pdsteer_pkg::PD_W-1){1'b1}}};
        end
    end

    // Integer angle, truncated toward zero: shift the magnitude and put the
    // sign back. Then clamp the angle and derive the duty from it.
    always_comb begin
        w_mag  = r_acc[pdsteer_pkg::ACC_W-1] ? -r_acc : r_acc;
        w_quot = w_mag[pdsteer_pkg::ACC_W-1:pdsteer_pkg::FRAC_SHIFT];
        w_angle_full = r_acc[pdsteer_pkg::ACC_W-1] ? -$signed({1'b0, w_quot})
                                                   :  $signed({1'b0, w_quot});
        if (w_angle_full > pdsteer_pkg::ANGLE_MAX) begin
            w_angle_clamp = pdsteer_pkg::ANGLE_MAX;
        end else if (w_angle_full < pdsteer_pkg::ANGLE_MIN) begin
            w_angle_clamp = pdsteer_pkg::ANGLE_MIN;
        end else begin
            w_angle_clamp = w_angle_full;
        end
        w_angle     = w_angle_clamp[pdsteer_pkg::ANGLE_W-1:0];
        w_duty_full = pdsteer_pkg::DUTY_CENTRE + (pdsteer_pkg::DUTY_W+1)'(w_angle);
        if (w_duty_full > pdsteer_pkg::DUTY_MAX) begin
            w_duty_clamp = pdsteer_pkg::DUTY_MAX;
        end else if (w_duty_full < pdsteer_pkg::DUTY_MIN) begin
            w_duty_clamp = pdsteer_pkg::DUTY_MIN;
        end else begin
            w_duty_clamp = w_duty_full;
        end
    end

    // Next state. The PD phase runs three steps (P product, D product,
    // final add), one step saturates and shifts the history, and the FIR
    // phase issues one product per tap plus a final add.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            pdsteer_pkg::S_IDLE: begin
                n_cnt = '0;
                if (w_in_acc) begin
                    n_state = pdsteer_pkg::S_PD;
                end
            end
            pdsteer_pkg::S_PD: begin
                if (r_cnt == PD_LAST) begin
                    n_state = pdsteer_pkg::S_LOAD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            pdsteer_pkg::S_LOAD: begin
                n_state = pdsteer_pkg::S_FIR;
                n_cnt   = '0;
            end
            pdsteer_pkg::S_FIR: begin
                if (r_cnt == FIR_LAST) begin
                    n_state = pdsteer_pkg::S_OUT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            pdsteer_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = pdsteer_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pdsteer_pkg::S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdsteer_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Gains in use: a configuration write loads one, a ring beat forces both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= pdsteer_pkg::PROP_GAIN_RESET;
            r_kd <= pdsteer_pkg::DERIV_GAIN_RESET;
        end else if (w_in_acc && i_ring_mode) begin
            r_kp <= pdsteer_pkg::RING_KP;
            r_kd <= pdsteer_pkg::RING_KD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdsteer_pkg::CFG_PROP_GAIN:  r_kp <= i_cfg_data;
                pdsteer_pkg::CFG_DERIV_GAIN: r_kd <= i_cfg_data;
                default: begin
                    r_kp <= r_kp;
                end
            endcase
        end
    end

    // Captured error.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= i_track_error;
        end
    end

    // Last error and PD history, updated once the PD term is final.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            for (int i = 0; i < HISTORY_TAPS; i++) begin
                r_hist[i] <= '0;
            end
        end else if (r_state == pdsteer_pkg::S_LOAD) begin
            r_last_err <= r_err;
            r_hist[0]  <= w_pd_sat;
            for (int i = 1; i < HISTORY_TAPS; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Product register and accumulator. The accumulator clears on the first
    // step of each phase and adds the previous step's product afterwards.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p[pdsteer_pkg::ACC_W-1:0];
        case (r_state)
            pdsteer_pkg::S_PD,
            pdsteer_pkg::S_FIR: begin
                if (r_cnt == '0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= r_acc + r_prod;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == pdsteer_pkg::S_OUT && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pdsteer_pkg::S_OUT && w_out_free) begin
            o_steer_angle <= w_angle;
            o_pwm_duty    <= w_duty_clamp[pdsteer_pkg::DUTY_W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PD steering core testbench
// Drives error beats through the PD steering core under random sender bursts
// and receiver stalls, predicts every steering angle and servo duty from an
// independent model of the PD term, the four-tap smoothing and the clamps,
// and checks each output beat against the oldest prediction. The gain
// registers are rewritten between phases, only while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;

    // Watchdog limit in clock cycles. It leaves plenty of headroom over the
    // slowest correct run.
    localparam int CYCLE_LIMIT = 600000;

    // Smoothing weights in Q0.8, newest PD term first.
    localparam longint SMOOTH_W0 = 205;
    localparam longint SMOOTH_W1 = 26;
    localparam longint SMOOTH_W2 = 15;
    localparam longint SMOOTH_W3 = 10;

    localparam int RANDOM_PHASES    = 8;
    localparam int BEATS_PER_PHASE  = 212;

    typedef struct {
        logic signed [pdsteer_pkg::ERR_W-1:0] err;
        logic                                 ring;
    } t_steer_beat;

    typedef struct {
        logic signed [pdsteer_pkg::ANGLE_W-1:0] angle;
        logic        [pdsteer_pkg::DUTY_W-1:0]  duty;
    } t_steer_result;

    // Every input starts at a known value.
    logic                                 i_clk         = 1'b0;
    logic                                 i_rst_n       = 1'b0;
    logic                                 i_in_valid    = 1'b0;
    logic signed [pdsteer_pkg::ERR_W-1:0] i_track_error = '0;
    logic                                 i_ring_mode   = 1'b0;
    logic                                 i_out_stall   = 1'b0;
    logic                                 i_cfg_we      = 1'b0;
    logic [pdsteer_pkg::CFG_IDX_W-1:0]    i_cfg_index   = pdsteer_pkg::CFG_PROP_GAIN;
    logic [pdsteer_pkg::GAIN_W-1:0]       i_cfg_data    = '0;

    wire                                    o_in_stall;
    wire                                    o_out_valid;
    wire signed [pdsteer_pkg::ANGLE_W-1:0]  o_steer_angle;
    wire        [pdsteer_pkg::DUTY_W-1:0]   o_pwm_duty;

    pd_steering_with_smoothing_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_track_error (i_track_error),
        .i_ring_mode   (i_ring_mode),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_steer_angle (o_steer_angle),
        .o_pwm_duty    (o_pwm_duty),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 time unit period: 6 high, 6 low.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Beats waiting to be sent, and the results predicted for beats that the
    // core has already accepted, oldest first.
    t_steer_beat   pending_beats[$];
    t_steer_result expected_steer[$];

    // Predictor state: the previous error, the last four PD terms and the
    // gains currently in use.
    logic signed [pdsteer_pkg::ERR_W-1:0]  prev_err;
    logic signed [pdsteer_pkg::PD_W-1:0]   pd_taps [pdsteer_pkg::HISTORY_TAPS_DEF];
    logic        [pdsteer_pkg::GAIN_W-1:0] kp_active;
    logic        [pdsteer_pkg::GAIN_W-1:0] kd_active;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Predicts the result of one accepted beat and advances the predictor
    // state exactly as the core should.
    function automatic t_steer_result predict_steering(input t_steer_beat b);
        longint        pd;
        longint        acc;
        longint        ang;
        longint        duty;
        t_steer_result r;
        // A ring element forces the gains before the PD term is formed, and
        // they stay forced until a gain register is written.
        if (b.ring) begin
            kp_active = pdsteer_pkg::RING_KP;
            kd_active = pdsteer_pkg::RING_KD;
        end
        // Q8.8 gain times Q8.8 error gives the PD term in Q16.16. Gains are
        // unsigned, so they are zero extended; the errors are sign extended.
        pd = longint'(kp_active) * longint'(b.err)
           + longint'(kd_active) * (longint'(b.err) - longint'(prev_err));
        if (pd > 64'sd2147483647) begin
            pd = 64'sd2147483647;
        end else if (pd < -64'sd2147483648) begin
            pd = -64'sd2147483648;
        end
        prev_err = b.err;
        pd_taps[3] = pd_taps[2];
        pd_taps[2] = pd_taps[1];
        pd_taps[1] = pd_taps[0];
        pd_taps[0] = pd[pdsteer_pkg::PD_W-1:0];
        acc = SMOOTH_W0 * longint'(pd_taps[0]) + SMOOTH_W1 * longint'(pd_taps[1])
            + SMOOTH_W2 * longint'(pd_taps[2]) + SMOOTH_W3 * longint'(pd_taps[3]);
        // Q.16 times Q0.8 is Q.24; drop the fraction, rounding toward zero.
        if (acc < 0) begin
            ang = -((-acc) >>> pdsteer_pkg::FRAC_SHIFT);
        end else begin
            ang = acc >>> pdsteer_pkg::FRAC_SHIFT;
        end
        if (ang > pdsteer_pkg::ANGLE_MAX) begin
            ang = pdsteer_pkg::ANGLE_MAX;
        end else if (ang < pdsteer_pkg::ANGLE_MIN) begin
            ang = pdsteer_pkg::ANGLE_MIN;
        end
        duty = pdsteer_pkg::DUTY_CENTRE + ang;
        if (duty > pdsteer_pkg::DUTY_MAX) begin
            duty = pdsteer_pkg::DUTY_MAX;
        end else if (duty < pdsteer_pkg::DUTY_MIN) begin
            duty = pdsteer_pkg::DUTY_MIN;
        end
        r.angle = ang[pdsteer_pkg::ANGLE_W-1:0];
        r.duty  = duty[pdsteer_pkg::DUTY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("cycle %0d: %s mismatch, got %0d, expected %0d", cycle_count, what, got,
                 want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver. It presents beats from the pending queue in bursts of random
    // length with random gaps in between. The prediction for a beat is made
    // at the edge where the core takes it, so it always sees the gains and
    // history that the core itself uses. A payload only changes once the
    // current beat has been taken, and valid gets one assignment per edge.
    // ------------------------------------------------------------------------
    int          burst_left = 0;
    int          gap_left   = 0;
    t_steer_beat beat_on_bus;

    always @(posedge i_clk) begin : driver
        t_steer_beat nb;
        logic        slot_free;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_steer.push_back(predict_steering(beat_on_bus));
            end
            slot_free = !i_in_valid || !o_in_stall;
            if (slot_free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nb = pending_beats.pop_front();
                    beat_on_bus = nb;
                    i_in_valid    <= 1'b1;
                    i_track_error <= nb.err;
                    i_ring_mode   <= nb.ring;
                    if (burst_left <= 1) begin
                        // Now and then a long burst with no idling at all.
                        burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern. Each time its tick counter wraps it picks a new
    // mode: no stall, light random stall, heavy random stall, or a square wave.
    // This puts stalls on every step of the core's sequence, with clean stretches too.
    // ------------------------------------------------------------------------
    int stall_mode  = 0;
    int stall_ticks = 0;

    always @(posedge i_clk) begin : stall_pattern
        if (stall_ticks == 49) begin
            stall_ticks = 0;
            stall_mode  = $urandom_range(0, 3);
        end else begin
            stall_ticks++;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= stall_ticks[2];
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor. Each output beat taken at an edge is compared field by field
    // with the oldest prediction. A beat with nothing predicted is a failure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_steer_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_steer.size() == 0) begin
                report_mismatch("unexpected result, steer_angle", int'(o_steer_angle), 0);
            end else begin
                want = expected_steer.pop_front();
                if (o_steer_angle !== want.angle) begin
                    report_mismatch("steer_angle", int'(o_steer_angle), int'(want.angle));
                end
                if (o_pwm_duty !== want.duty) begin
                    report_mismatch("pwm_duty", int'(o_pwm_duty), int'(want.duty));
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_beat(input logic signed [pdsteer_pkg::ERR_W-1:0] err,
                            input logic ring);
        t_steer_beat b;
        b.err  = err;
        b.ring = ring;
        pending_beats.push_back(b);
    endtask

    // Waits until every queued beat has been sent and every predicted result
    // has come back, then lets the core's latency pass once more.
    task automatic wait_quiet();
        while (pending_beats.size() != 0 || i_in_valid || expected_steer.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    // One register write; only called while the core is idle, so the
    // predictor can take the new gain at once.
    task automatic write_gain(input logic [pdsteer_pkg::CFG_IDX_W-1:0] idx,
                              input logic [pdsteer_pkg::GAIN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pdsteer_pkg::CFG_PROP_GAIN) begin
            kp_active = val;
        end else begin
            kd_active = val;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence: reset, three directed phases, then random phases
    // with fresh gains each. The sender pauses between phases until every
    // result has come back, which is when the gains are changed.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic signed [pdsteer_pkg::ERR_W-1:0] walk;
        logic [pdsteer_pkg::GAIN_W-1:0]       gp;
        logic [pdsteer_pkg::GAIN_W-1:0]       gd;
        int                                   w;
        int                                   pick;
        prev_err  = '0;
        kp_active = pdsteer_pkg::PROP_GAIN_RESET;
        kd_active = pdsteer_pkg::DERIV_GAIN_RESET;
        for (int k = 0; k < pdsteer_pkg::HISTORY_TAPS_DEF; k++) begin
            pd_taps[k] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Reset gains: zero, unit steps, both field extremes (the angle
        // clamps at both ends), and a ring beat.
        @(negedge i_clk);
        add_beat(16'sd0, 1'b0);
        add_beat(16'sd1, 1'b0);
        add_beat(-16'sd1, 1'b0);
        add_beat(16'sd32767, 1'b0);
        add_beat(16'sd32767, 1'b0);
        add_beat(-16'sd32768, 1'b0);
        add_beat(-16'sd32768, 1'b0);
        add_beat(16'sd256, 1'b1);
        add_beat(-16'sd256, 1'b0);
        wait_quiet();

        // Largest gains: the PD term saturates at both ends of its range. The
        // ring beat then drops the gains back to the forced values.
        write_gain(pdsteer_pkg::CFG_PROP_GAIN, 16'hFFFF);
        write_gain(pdsteer_pkg::CFG_DERIV_GAIN, 16'hFFFF);
        @(negedge i_clk);
        add_beat(16'sd32767, 1'b0);
        add_beat(-16'sd32768, 1'b0);
        add_beat(16'sd32767, 1'b0);
        add_beat(16'sd0, 1'b0);
        add_beat(-16'sd32768, 1'b1);
        add_beat(16'sd100, 1'b0);
        wait_quiet();

        // Zero gains: the smoothed history decays to nothing.
        write_gain(pdsteer_pkg::CFG_DERIV_GAIN, 16'h0000);
        write_gain(pdsteer_pkg::CFG_PROP_GAIN, 16'h0000);
        @(negedge i_clk);
        add_beat(16'sd500, 1'b0);
        add_beat(-16'sd500, 1'b0);
        add_beat(16'sd0, 1'b0);
        add_beat(16'sd0, 1'b0);
        add_beat(16'sd1000, 1'b1);
        wait_quiet();

        walk = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    gp = pdsteer_pkg::GAIN_W'($urandom_range(0, 65535));
                    gd = pdsteer_pkg::GAIN_W'($urandom_range(0, 65535));
                end
                1: begin
                    gp = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    gd = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                end
                2: begin
                    gp = pdsteer_pkg::GAIN_W'($urandom_range(0, 2047));
                    gd = pdsteer_pkg::GAIN_W'($urandom_range(0, 2047));
                end
                default: begin
                    gp = pdsteer_pkg::GAIN_W'($urandom_range(0, 65535));
                    gd = pdsteer_pkg::GAIN_W'($urandom_range(0, 4095));
                end
            endcase
            if ($urandom_range(0, 1) != 0) begin
                write_gain(pdsteer_pkg::CFG_PROP_GAIN, gp);
                write_gain(pdsteer_pkg::CFG_DERIV_GAIN, gd);
            end else begin
                write_gain(pdsteer_pkg::CFG_DERIV_GAIN, gd);
                write_gain(pdsteer_pkg::CFG_PROP_GAIN, gp);
            end
            @(negedge i_clk);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // Mostly a smooth track error like a real sensor gives, with
                // jumps, full-range noise and extremes mixed in.
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    w = int'(walk) + int'($urandom_range(0, 1023)) - 512;
                    if (w > 32767) begin
                        w = 32767;
                    end else if (w < -32768) begin
                        w = -32768;
                    end
                    walk = w[pdsteer_pkg::ERR_W-1:0];
                end else if (pick < 75) begin
                    walk = pdsteer_pkg::ERR_W'($urandom_range(0, 65535));
                end else if (pick < 85) begin
                    walk = pdsteer_pkg::ERR_W'(int'($urandom_range(0, 63)) - 32);
                end else if (pick < 95) begin
                    walk = ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
                end else begin
                    walk = -walk;
                end
                add_beat(walk, $urandom_range(0, 99) < 8);
            end
            wait_quiet();
        end

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
